FILE: design/ssud_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted set bank.
package ssud_pkg;

    localparam int NUM_SETS  = 8;
    localparam int SET_DEPTH = 32;

    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int ENT_AW    = SET_W + IDX_W;
    localparam int ENT_DEPTH = 1 << ENT_AW;

    localparam int DATA_W    = 32;
    localparam int KIND_W    = 3;
    localparam int SEL_W     = 3;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 6;
    localparam int STATUS_W  = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_UNION = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_DIFF  = KIND_W'(2);
    localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(3);
    localparam logic [KIND_W-1:0] KIND_CLEAR = KIND_W'(4);

    localparam logic [STATUS_W-1:0] STS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STS_FULL  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STS_ORDER = STATUS_W'(2);
    localparam logic [STATUS_W-1:0] STS_POS   = STATUS_W'(3);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_T,
        ST_CNT_S,
        ST_LOAD,
        ST_READ,
        ST_M_CAB,
        ST_M_CA,
        ST_M_CB,
        ST_M_STEP,
        ST_COPY,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_LAST,
        RD_POS,
        RD_A,
        RD_B
    } t_rd_src;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_CLEAR,
        CNT_SET_N
    } t_cnt_op;

    typedef struct packed {
        logic    capture;
        logic    get_na;
        logic    get_nb;
        t_rd_src rd_src;
        logic    cap_a;
        logic    cap_b;
        logic    step;
        logic    finish_merge;
        logic    copy;
        logic    load_do;
        logic    read_do;
        t_cnt_op cnt_op;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              same_set;
        logic              merge_end;
        logic              take_a;
        logic              take_b;
        logic              copy_last;
    } t_sts;

    // set select folded into the bank; with eight sets a 3-bit field needs no subtract step
    function automatic logic [SET_W-1:0] set_index(input logic [SEL_W-1:0] x);
        int v;
        v = int'(x);
        for (int k = 0; k < 4; k++) begin
            if (v >= NUM_SETS) begin
                v = v - NUM_SETS;
            end
        end
        return SET_W'(v);
    endfunction

endpackage

FILE: design/ssud_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssud_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ssud_ctrl.sv
// Controller state machine sequencing load, read, clear, union and difference transactions.
module ssud_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  ssud_pkg::t_sts i_sts,
    output ssud_pkg::t_cmd o_cmd
);

    ssud_pkg::t_state r_state;
    ssud_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssud_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            ssud_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ssud_pkg::ST_CNT_T;
                end
            end
            ssud_pkg::ST_CNT_T: begin
                o_cmd.get_na = 1'b1;
                n_state      = ssud_pkg::ST_CNT_S;
            end
            ssud_pkg::ST_CNT_S: begin
                o_cmd.get_nb = 1'b1;
                case (i_sts.kind)
                    ssud_pkg::KIND_LOAD: begin
                        o_cmd.rd_src = ssud_pkg::RD_LAST;
                        n_state      = ssud_pkg::ST_LOAD;
                    end
                    ssud_pkg::KIND_READ: begin
                        o_cmd.rd_src = ssud_pkg::RD_POS;
                        n_state      = ssud_pkg::ST_READ;
                    end
                    ssud_pkg::KIND_UNION: begin
                        if (i_sts.same_set) begin
                            n_state = ssud_pkg::ST_DONE;
                        end else begin
                            o_cmd.rd_src = ssud_pkg::RD_A;
                            n_state      = ssud_pkg::ST_M_CAB;
                        end
                    end
                    ssud_pkg::KIND_DIFF: begin
                        if (i_sts.same_set) begin
                            o_cmd.cnt_op = ssud_pkg::CNT_CLEAR;
                            n_state      = ssud_pkg::ST_DONE;
                        end else begin
                            o_cmd.rd_src = ssud_pkg::RD_A;
                            n_state      = ssud_pkg::ST_M_CAB;
                        end
                    end
                    ssud_pkg::KIND_CLEAR: begin
                        o_cmd.cnt_op = ssud_pkg::CNT_CLEAR;
                        n_state      = ssud_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = ssud_pkg::ST_DONE;
                    end
                endcase
            end
            ssud_pkg::ST_LOAD: begin
                o_cmd.load_do = 1'b1;
                n_state       = ssud_pkg::ST_DONE;
            end
            ssud_pkg::ST_READ: begin
                o_cmd.read_do = 1'b1;
                n_state       = ssud_pkg::ST_DONE;
            end
            ssud_pkg::ST_M_CAB: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_src = ssud_pkg::RD_B;
                n_state      = ssud_pkg::ST_M_CB;
            end
            ssud_pkg::ST_M_CA: begin
                o_cmd.cap_a = 1'b1;
                n_state     = ssud_pkg::ST_M_STEP;
            end
            ssud_pkg::ST_M_CB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = ssud_pkg::ST_M_STEP;
            end
            ssud_pkg::ST_M_STEP: begin
                if (i_sts.merge_end) begin
                    o_cmd.finish_merge = 1'b1;
                    if (i_sts.kind == ssud_pkg::KIND_UNION) begin
                        n_state = ssud_pkg::ST_COPY;
                    end else begin
                        o_cmd.cnt_op = ssud_pkg::CNT_SET_N;
                        n_state      = ssud_pkg::ST_DONE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.take_a && i_sts.take_b) begin
                        o_cmd.rd_src = ssud_pkg::RD_A;
                        n_state      = ssud_pkg::ST_M_CAB;
                    end else if (i_sts.take_a) begin
                        o_cmd.rd_src = ssud_pkg::RD_A;
                        n_state      = ssud_pkg::ST_M_CA;
                    end else begin
                        o_cmd.rd_src = ssud_pkg::RD_B;
                        n_state      = ssud_pkg::ST_M_CB;
                    end
                end
            end
            ssud_pkg::ST_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.copy_last) begin
                    o_cmd.cnt_op = ssud_pkg::CNT_SET_N;
                    n_state      = ssud_pkg::ST_DONE;
                end
            end
            ssud_pkg::ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = ssud_pkg::ST_IDLE;
            end
            default: begin
                n_state = ssud_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/ssud_datapath.sv
// Datapath: set counts, entry and scratch RAMs, merge compare step and result registers.
module ssud_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ssud_pkg::t_cmd                        i_cmd,
    output ssud_pkg::t_sts                        o_sts,
    input  logic [ssud_pkg::KIND_W-1:0]           i_kind,
    input  logic [ssud_pkg::SEL_W-1:0]            i_target_set,
    input  logic [ssud_pkg::SEL_W-1:0]            i_source_set,
    input  logic signed [ssud_pkg::DATA_W-1:0]    i_value,
    input  logic [ssud_pkg::POS_W-1:0]            i_position,
    output logic                                  o_strobe,
    output logic signed [ssud_pkg::DATA_W-1:0]    o_read_value,
    output logic [ssud_pkg::COUNT_W-1:0]          o_count,
    output logic [ssud_pkg::STATUS_W-1:0]         o_status
);

    // latched transaction
    logic [ssud_pkg::KIND_W-1:0]        r_kind;
    logic [ssud_pkg::SET_W-1:0]         r_t;
    logic [ssud_pkg::SET_W-1:0]         r_s;
    logic signed [ssud_pkg::DATA_W-1:0] r_value;
    logic [ssud_pkg::POS_W-1:0]         r_pos;

    // walk state
    logic [ssud_pkg::CNT_W-1:0]         r_na;
    logic [ssud_pkg::CNT_W-1:0]         r_nb;
    logic [ssud_pkg::CNT_W-1:0]         r_i;
    logic [ssud_pkg::CNT_W-1:0]         r_j;
    logic [ssud_pkg::CNT_W-1:0]         r_n;
    logic [ssud_pkg::CNT_W-1:0]         n_i;
    logic [ssud_pkg::CNT_W-1:0]         n_j;
    logic [ssud_pkg::CNT_W-1:0]         n_n;
    logic signed [ssud_pkg::DATA_W-1:0] r_a;
    logic signed [ssud_pkg::DATA_W-1:0] r_b;

    logic [ssud_pkg::STATUS_W-1:0]      r_status;
    logic signed [ssud_pkg::DATA_W-1:0] r_rd;

    logic [ssud_pkg::CNT_W-1:0]         r_cnt [ssud_pkg::NUM_SETS];

    logic                               r_o_valid;
    logic signed [ssud_pkg::DATA_W-1:0] r_o_value;
    logic [ssud_pkg::COUNT_W-1:0]       r_o_count;
    logic [ssud_pkg::STATUS_W-1:0]      r_o_status;

    // RAM ports
    logic                               ent_we;
    logic [ssud_pkg::ENT_AW-1:0]        ent_waddr;
    logic [ssud_pkg::DATA_W-1:0]        ent_wdata;
    logic [ssud_pkg::ENT_AW-1:0]        ent_raddr;
    logic [ssud_pkg::DATA_W-1:0]        ent_rdata;
    logic                               scr_we;
    logic [ssud_pkg::IDX_W-1:0]         scr_waddr;
    logic [ssud_pkg::DATA_W-1:0]        scr_wdata;
    logic [ssud_pkg::IDX_W-1:0]         scr_raddr;
    logic [ssud_pkg::DATA_W-1:0]        scr_rdata;

    logic [ssud_pkg::CNT_W-1:0]         cnt_rd;
    logic [ssud_pkg::CNT_W-1:0]         na_last;
    logic [ssud_pkg::CNT_W-1:0]         copy_w;
    logic                               is_union;
    logic                               a_ok;
    logic                               b_ok;
    logic                               eq;
    logic                               a_lt_b;
    logic                               full_n;
    logic                               merge_end;
    logic                               take_a;
    logic                               take_b;
    logic                               keep;
    logic                               trunc;
    logic signed [ssud_pkg::DATA_W-1:0] merge_v;
    logic                               load_bad_order;
    logic                               load_full;
    logic                               load_ok;
    logic                               pos_ok;

    ssud_ram #(
        .WIDTH(ssud_pkg::DATA_W),
        .DEPTH(ssud_pkg::ENT_DEPTH)
    ) u_entries (
        .i_clk  (i_clk),
        .i_we   (ent_we),
        .i_waddr(ent_waddr),
        .i_wdata(ent_wdata),
        .i_raddr(ent_raddr),
        .o_rdata(ent_rdata)
    );

    ssud_ram #(
        .WIDTH(ssud_pkg::DATA_W),
        .DEPTH(ssud_pkg::SET_DEPTH)
    ) u_scratch (
        .i_clk  (i_clk),
        .i_we   (scr_we),
        .i_waddr(scr_waddr),
        .i_wdata(scr_wdata),
        .i_raddr(scr_raddr),
        .o_rdata(scr_rdata)
    );

    // one count read port: source set while fetching its count, target otherwise
    assign cnt_rd   = r_cnt[i_cmd.get_nb ? r_s : r_t];
    assign na_last  = r_na - ssud_pkg::CNT_W'(1);
    assign copy_w   = r_i - ssud_pkg::CNT_W'(1);
    assign is_union = (r_kind == ssud_pkg::KIND_UNION);

    assign a_ok   = (r_i < r_na);
    assign b_ok   = (r_j < r_nb);
    assign eq     = (r_a == r_b);
    assign a_lt_b = (r_a < r_b);
    assign full_n = (r_n == ssud_pkg::CNT_W'(ssud_pkg::SET_DEPTH));

    always_comb begin
        if (is_union) begin
            merge_end = (!a_ok && !b_ok) || full_n;
            take_a    = a_ok && (!b_ok || !a_lt_b);
            take_b    = b_ok && (!a_ok || eq || a_lt_b);
            keep      = 1'b1;
        end else begin
            // difference: drop matches, skip source entries above the target head
            merge_end = !a_ok;
            take_b    = b_ok && (eq || a_lt_b);
            take_a    = !b_ok || !a_lt_b;
            keep      = !take_b;
        end
    end

    assign trunc   = is_union && (a_ok || b_ok) && full_n;
    assign merge_v = take_a ? r_a : r_b;

    assign load_bad_order = (r_na != '0) && !(r_value < $signed(ent_rdata));
    assign load_full      = (r_na >= ssud_pkg::CNT_W'(ssud_pkg::SET_DEPTH));
    assign load_ok        = !load_bad_order && !load_full;
    assign pos_ok         = (32'(r_pos) < 32'(r_na));

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_n = r_n;
        if (i_cmd.capture) begin
            n_i = '0;
            n_j = '0;
            n_n = '0;
        end else if (i_cmd.step) begin
            n_i = r_i + ssud_pkg::CNT_W'(take_a);
            n_j = r_j + ssud_pkg::CNT_W'(take_b);
            n_n = r_n + ssud_pkg::CNT_W'(keep);
        end else if (i_cmd.finish_merge) begin
            n_i = '0;
        end else if (i_cmd.copy) begin
            n_i = r_i + ssud_pkg::CNT_W'(1);
        end
    end

    // read address uses next indices so a step can fetch the following entry at once
    always_comb begin
        case (i_cmd.rd_src)
            ssud_pkg::RD_LAST: ent_raddr = {r_t, na_last[ssud_pkg::IDX_W-1:0]};
            ssud_pkg::RD_POS:  ent_raddr = {r_t, ssud_pkg::IDX_W'(r_pos)};
            ssud_pkg::RD_A:    ent_raddr = {r_t, n_i[ssud_pkg::IDX_W-1:0]};
            ssud_pkg::RD_B:    ent_raddr = {r_s, n_j[ssud_pkg::IDX_W-1:0]};
            default:           ent_raddr = {r_t, n_i[ssud_pkg::IDX_W-1:0]};
        endcase
    end

    always_comb begin
        ent_we    = 1'b0;
        ent_waddr = {r_t, r_n[ssud_pkg::IDX_W-1:0]};
        ent_wdata = r_a;
        if (i_cmd.load_do) begin
            ent_we    = load_ok;
            ent_waddr = {r_t, r_na[ssud_pkg::IDX_W-1:0]};
            ent_wdata = r_value;
        end else if (i_cmd.step) begin
            ent_we    = !is_union && keep;
        end else if (i_cmd.copy) begin
            ent_we    = (r_i != '0);
            ent_waddr = {r_t, copy_w[ssud_pkg::IDX_W-1:0]};
            ent_wdata = scr_rdata;
        end
    end

    assign scr_we    = i_cmd.step && is_union;
    assign scr_waddr = r_n[ssud_pkg::IDX_W-1:0];
    assign scr_wdata = merge_v;
    assign scr_raddr = r_i[ssud_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind   <= i_kind;
            r_t      <= ssud_pkg::set_index(i_target_set);
            r_s      <= ssud_pkg::set_index(i_source_set);
            r_value  <= i_value;
            r_pos    <= i_position;
            r_status <= ssud_pkg::STS_OK;
            r_rd     <= '0;
        end
        if (i_cmd.get_na) begin
            r_na <= cnt_rd;
        end
        if (i_cmd.get_nb) begin
            r_nb <= cnt_rd;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_n <= n_n;
        if (i_cmd.cap_a) begin
            r_a <= ent_rdata;
        end
        if (i_cmd.cap_b) begin
            r_b <= ent_rdata;
        end
        if (i_cmd.finish_merge && trunc) begin
            r_status <= ssud_pkg::STS_FULL;
        end
        if (i_cmd.load_do) begin
            if (load_bad_order) begin
                r_status <= ssud_pkg::STS_ORDER;
            end else if (load_full) begin
                r_status <= ssud_pkg::STS_FULL;
            end
        end
        if (i_cmd.read_do) begin
            if (pos_ok) begin
                r_rd <= ent_rdata;
            end else begin
                r_status <= ssud_pkg::STS_POS;
            end
        end
        if (i_cmd.emit) begin
            r_o_value  <= r_rd;
            r_o_count  <= ssud_pkg::COUNT_W'(cnt_rd);
            r_o_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            for (int k = 0; k < ssud_pkg::NUM_SETS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_o_valid <= i_cmd.emit;
            if (i_cmd.load_do && load_ok) begin
                r_cnt[r_t] <= r_na + ssud_pkg::CNT_W'(1);
            end
            case (i_cmd.cnt_op)
                ssud_pkg::CNT_CLEAR: r_cnt[r_t] <= '0;
                ssud_pkg::CNT_SET_N: r_cnt[r_t] <= r_n;
                default: ;
            endcase
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.same_set  = (r_t == r_s);
    assign o_sts.merge_end = merge_end;
    assign o_sts.take_a    = take_a;
    assign o_sts.take_b    = take_b;
    assign o_sts.copy_last = (r_i == r_n);

    assign o_strobe     = r_o_valid;
    assign o_read_value = r_o_value;
    assign o_count      = r_o_count;
    assign o_status     = r_o_status;

endmodule

FILE: design/sorted_set_union_difference.sv
// Top level of the sorted set bank: controller, datapath and result checks.
//
// A bank of eight signed 32-bit sets, each up to 32 entries, held strictly
// descending (entry 0 largest) with a per-set count. A transaction is taken
// when start is high and busy is low; busy then stays high until the result
// is out. Every transaction gives exactly one result, shown for one cycle on
// o_read_value/o_count/o_status with o_strobe high. The receiver cannot stall,
// so capture it on the strobe; busy is already low in that cycle and the next
// transaction may be issued then. Clear, union or difference of a set with
// itself and unknown kinds finish once both counts are fetched; load and
// read add one entry access; union and difference merge the two sets,
// slowest for a union of two full sets holding the same values. Merge time
// is set by the entry RAM, which has a single read port, so each merge step
// refetches one set head, or both on a match, before the next compare; the
// union is also built in a scratch RAM and copied back one entry a cycle.
// Counts sit in flip-flops and reset to zero, so no clearing pass is
// needed; set entries are not initialised.
// Status: 0 ok, 1 set full or union truncated to the 32 largest,
// 2 load not below the last entry (dropped), 3 read beyond count (value 0).
module sorted_set_union_difference (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ssud_pkg::KIND_W-1:0]        i_kind,
    input  logic [ssud_pkg::SEL_W-1:0]         i_target_set,
    input  logic [ssud_pkg::SEL_W-1:0]         i_source_set,
    input  logic signed [ssud_pkg::DATA_W-1:0] i_value,
    input  logic [ssud_pkg::POS_W-1:0]         i_position,
    output logic                               o_strobe,
    output logic signed [ssud_pkg::DATA_W-1:0] o_read_value,
    output logic [ssud_pkg::COUNT_W-1:0]       o_count,
    output logic [ssud_pkg::STATUS_W-1:0]      o_status
);

    ssud_pkg::t_cmd cmd;
    ssud_pkg::t_sts sts;

    // sequencing only: issues commands, watches compare outcome
    ssud_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .o_busy (busy),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    // storage, merge compare and the registered result
    ssud_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_target_set(i_target_set),
        .i_source_set(i_source_set),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_strobe    (o_strobe),
        .o_read_value(o_read_value),
        .o_count     (o_count),
        .o_status    (o_status)
    );

`ifndef SYNTHESIS
    // accepted transaction must hold the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // end of a transaction and its result coincide
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy fell without a result strobe");

    // one result per transaction, never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for two cycles");

    // out-of-range read returns zero
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ssud_pkg::STS_POS)) |-> (o_read_value == '0))
        else $error("non-zero value with position status");
`endif

endmodule
